// File: rtl/core/smrc_pkg.sv
// shared constants for the square matrix rotator
package smrc_pkg;

    // element width, fixed by the data format
    localparam int DATA_W = 32;

    // side length register
    localparam int MATRIX_SIZE_W = 4;
    localparam logic [MATRIX_SIZE_W-1:0] MATRIX_SIZE_RESET = 4'd8;

endpackage

// File: rtl/core/smrc_fifo2.sv
// two-entry first-in first-out queue with occupancy count
module smrc_fifo2 #(
    parameter int WIDTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty,
    output logic [1:0]       count
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = data_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign count    = count_reg;

endmodule

// File: rtl/core/smrc_front.sv
// load side: side length register, element counter and buffer writes
module smrc_front #(
    parameter int MAX_SIDE = 8,
    parameter int SIDE_W   = 4,
    parameter int ADDR_W   = 6
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [smrc_pkg::MATRIX_SIZE_W-1:0]      cfg_wr_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [smrc_pkg::DATA_W-1:0]      s_element_value,
    output logic                                    wr_en,
    output logic [ADDR_W:0]                         wr_addr,
    output logic [smrc_pkg::DATA_W-1:0]             wr_data,
    output logic                                    job_push,
    output logic [SIDE_W:0]                         job_data,
    input  logic                                    job_full
);

    import smrc_pkg::*;

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int TOT_W = 2 * SIDE_W;

    logic [MATRIX_SIZE_W-1:0] matrix_size_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     bank_reg;
    logic [SIDE_W-1:0]        side;
    logic [TOT_W-1:0]         total;
    logic [CNT_W-1:0]         count_inc;
    logic                     accept;
    logic                     complete;

    // zero reads as one, oversize saturates
    always_comb begin
        if (matrix_size_reg == '0) begin
            side = SIDE_W'(1);
        end else if (32'(matrix_size_reg) > MAX_SIDE) begin
            side = SIDE_W'(MAX_SIDE);
        end else begin
            side = SIDE_W'(matrix_size_reg);
        end
    end

    assign total     = TOT_W'(side) * TOT_W'(side);
    assign accept    = s_valid && s_ready;
    assign count_inc = count_reg + CNT_W'(1);
    assign complete  = accept && (32'(count_inc) >= 32'(total));

    always_comb begin
        count_next = count_reg;
        if (complete) begin
            count_next = '0;
        end else if (accept) begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg <= MATRIX_SIZE_RESET;
            count_reg       <= '0;
            bank_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                matrix_size_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            if (complete) begin
                bank_reg <= ~bank_reg;
            end
        end
    end

    // one bank fills while the other drains
    assign s_ready  = !job_full;
    assign wr_en    = accept && (32'(count_reg) < CELLS);
    assign wr_addr  = {bank_reg, count_reg[ADDR_W-1:0]};
    assign wr_data  = s_element_value;
    assign job_push = complete;
    assign job_data = {bank_reg, side};

endmodule

// File: rtl/core/smrc_back.sv
// emit side: banked matrix memory, rotated read order and output buffer
module smrc_back #(
    parameter int MAX_SIDE = 8,
    parameter int SIDE_W   = 4,
    parameter int IDX_W    = 3,
    parameter int ADDR_W   = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [ADDR_W:0]                    wr_addr,
    input  logic [smrc_pkg::DATA_W-1:0]        wr_data,
    input  logic                               job_valid,
    input  logic [SIDE_W:0]                    job_data,
    output logic                               job_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [smrc_pkg::DATA_W-1:0] m_rotated_value,
    output logic                               m_last_of_matrix
);

    import smrc_pkg::*;

    localparam int MEM_DEPTH = 2 * (2 ** ADDR_W);
    localparam int TOT_W     = 2 * SIDE_W;

    logic [DATA_W-1:0] mem [MEM_DEPTH];

    logic              busy_reg;
    logic              bank_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] acc_reg;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  col_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              p1_valid_reg;
    logic              p1_last_reg;

    logic [SIDE_W-1:0] job_side;
    logic              job_bank;
    logic [ADDR_W-1:0] job_base;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W:0]   rd_addr;
    logic              last_col;
    logic              last_row;
    logic              is_last;
    logic              room;
    logic              issue;
    logic              start;

    logic              out_pop;
    logic              out_full;
    logic              out_empty;
    logic [1:0]        out_count;
    logic [DATA_W:0]   out_data;

    assign job_side = job_data[SIDE_W-1:0];
    assign job_bank = job_data[SIDE_W];
    // first source of each row: bottom row of the loaded matrix
    assign job_base = ADDR_W'((TOT_W'(job_side) - TOT_W'(1)) * TOT_W'(job_side));

    assign src      = acc_reg + ADDR_W'(row_reg);
    assign rd_addr  = {bank_reg, src};
    assign last_col = (32'(col_reg) + 1 == 32'(side_reg));
    assign last_row = (32'(row_reg) + 1 == 32'(side_reg));
    assign is_last  = last_col && last_row;

    // reads in flight plus buffered results never exceed the buffer
    assign out_pop = m_valid && m_ready;
    assign room    = ({1'b0, out_count} + {2'b00, p1_valid_reg}) < (3'd2 + {2'b00, out_pop});
    assign issue   = busy_reg && room;
    assign start   = !busy_reg && job_valid;
    assign job_pop = issue && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= issue;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (job_pop) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // walk up one column of the source per output row
    always_ff @(posedge aclk) begin
        if (start) begin
            bank_reg <= job_bank;
            side_reg <= job_side;
            base_reg <= job_base;
            acc_reg  <= job_base;
            row_reg  <= '0;
            col_reg  <= '0;
        end else if (issue) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= row_reg + IDX_W'(1);
                acc_reg <= base_reg;
            end else begin
                col_reg <= col_reg + IDX_W'(1);
                acc_reg <= acc_reg - ADDR_W'(side_reg);
            end
        end
        if (issue) begin
            p1_last_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    smrc_fifo2 #(
        .WIDTH (DATA_W + 1)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p1_valid_reg),
        .push_data ({p1_last_reg, rdata_reg}),
        .pop       (out_pop),
        .pop_data  (out_data),
        .full      (out_full),
        .empty     (out_empty),
        .count     (out_count)
    );

    assign m_valid          = !out_empty;
    assign m_rotated_value  = out_data[DATA_W-1:0];
    assign m_last_of_matrix = out_data[DATA_W];

    a_issue_needs_job: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> job_valid)
        else $error("read issued with no job at the queue head");

    a_no_out_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> (!out_full || out_pop))
        else $error("read data arrived at a full output buffer");

    a_indices_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (32'(row_reg) < 32'(side_reg)) && (32'(col_reg) < 32'(side_reg)))
        else $error("row or column index beyond the side length");

    a_pop_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |=> !busy_reg)
        else $error("walk still busy after its job left the queue");

endmodule

// File: rtl/core/square_matrix_rotate_clockwise_unit.sv
// top level of the square matrix rotator, 90 degrees clockwise
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-----------------------------------
//  s_       | in        | s_valid/s_ready  | s_element_value, row-major load
//  m_       | out       | m_valid/m_ready  | m_rotated_value, m_last_of_matrix
//  cfg_     | in        | cfg_wr_en        | cfg_wr_data, side length N
//
//  one element is taken per cycle while a bank is free; a matrix is emitted as
//  a set-up step, then one memory read a cycle while the output buffer has room;
//  the first result passes the job queue, walk set-up, read register and buffer
//  two banks let the next matrix load while the last one drains, so the read
//  walk, with its set-up step per matrix, sets the sustained rate on each side
//  reset is synchronous and active low; the memory is not cleared
//  s_ready falls only while both banks hold matrices waiting to be emitted;
//  an m_ready stall holds the read walk once the two-entry output buffer fills
module square_matrix_rotate_clockwise_unit #(
    parameter int MAX_SIDE = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [smrc_pkg::MATRIX_SIZE_W-1:0] cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [smrc_pkg::DATA_W-1:0] s_element_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [smrc_pkg::DATA_W-1:0] m_rotated_value,
    output logic                               m_last_of_matrix
);

    import smrc_pkg::*;

    // side needs to hold MAX_SIDE itself, indices only up to MAX_SIDE - 1
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    // buffer write port, front to back
    logic              wr_en;
    logic [ADDR_W:0]   wr_addr;
    logic [DATA_W-1:0] wr_data;

    // job queue: bank and side length of each complete matrix
    logic              job_push;
    logic [SIDE_W:0]   job_push_data;
    logic              job_full;
    logic              job_empty;
    logic              job_pop;
    logic [SIDE_W:0]   job_head;
    logic [1:0]        job_count;

    // front: config register, load counter, completion detect
    smrc_front #(
        .MAX_SIDE (MAX_SIDE),
        .SIDE_W   (SIDE_W),
        .ADDR_W   (ADDR_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .job_push        (job_push),
        .job_data        (job_push_data),
        .job_full        (job_full)
    );

    // a queued job keeps its bank until the last read of it is issued
    smrc_fifo2 #(
        .WIDTH (SIDE_W + 1)
    ) u_job_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_push_data),
        .pop       (job_pop),
        .pop_data  (job_head),
        .full      (job_full),
        .empty     (job_empty),
        .count     (job_count)
    );

    // back: rotated read walk and result output
    smrc_back #(
        .MAX_SIDE (MAX_SIDE),
        .SIDE_W   (SIDE_W),
        .IDX_W    (IDX_W),
        .ADDR_W   (ADDR_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .job_valid        (!job_empty),
        .job_data         (job_head),
        .job_pop          (job_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rotated_value  (m_rotated_value),
        .m_last_of_matrix (m_last_of_matrix)
    );

    a_job_queue_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_push |-> !job_full || job_pop) and (job_full |-> job_count == 2'd2))
        else $error("job queue overflow");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> job_full)
        else $error("input stalled with a free bank");

    a_fill_bank_not_draining: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !job_empty) |-> (wr_addr[ADDR_W] != job_head[SIDE_W]))
        else $error("write into the bank being emitted");

endmodule
